// ===== src/assert_macros.svh =====
// Assertion macros for the checker file of the gradient magnitude block.
// Depends on nothing; included by gmt_checker.sv, which holds the concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GMT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define GMT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ===== src/gmt_pkg.sv =====
// Package of the gradient magnitude block: widths, register indexes, job type, states.
// Depends on nothing; used by every other file of the block but assert_macros.svh.
`default_nettype none

package gmt_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = 12;
   localparam int PIX_W       = 8;
   localparam int MAG_W       = 13;
   localparam int CSR_W       = 13;
   localparam int CSR_IDX_W   = 2;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 12;
   localparam int DIFF_W      = PIX_W + 1;
   localparam int SUMSQ_W     = 2 * PIX_W + 1;
   localparam int RAD_W       = SUMSQ_W + 8;
   localparam int TSQ_W       = 2 * MAG_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int MAG_MAX     = 5770;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
   localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_THRESHOLD    = 2'd2
   } csr_index_type;

   // One result to be computed by the back end.
   typedef struct packed {
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [ROW_W-1:0]         row;
      logic [COL_W-1:0]         col;
      logic                     last;
      logic                     frame_done;
   } gmt_job_type;

   // Handshake between the front end and the queue.
   typedef struct packed {
      logic        valid;
      gmt_job_type job;
   } gmt_push_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_CALC,
      F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE,
      B_ROOT,
      B_OUT
   } back_state_type;

endpackage

`default_nettype wire

// ===== src/gmt_if.sv =====
// Channel interfaces of the gradient magnitude block: pixel input and result output.
// Depends on gmt_pkg for field widths.
`default_nettype none

interface gmt_pixel_if;
   import gmt_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel;
   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface gmt_result_if;
   import gmt_pkg::*;
   logic             valid;
   logic             ready;
   logic [MAG_W-1:0] magnitude;
   logic [ROW_W-1:0] out_row;
   logic [COL_W-1:0] out_column;
   logic             last_in_run;
   logic             frame_done;
   modport source (output valid, output magnitude, output out_row, output out_column,
                   output last_in_run, output frame_done, input ready);
   modport sink (input valid, input magnitude, input out_row, input out_column,
                 input last_in_run, input frame_done, output ready);
endinterface

`default_nettype wire

// ===== src/gmt_front.sv =====
// Front end: tracks the raster position, keeps the two line stores and turns
// each pixel into up to three result jobs. Depends on gmt_pkg and gmt_if.
`default_nettype none

module gmt_front (
   input  wire                        clock,
   input  wire                        reset,
   gmt_pixel_if.sink                  req,
   input  wire [gmt_pkg::WIDTH_W-1:0] cfg_width,
   input  wire [gmt_pkg::HEIGHT_W-1:0] cfg_height,
   input  wire                        queue_full,
   output gmt_pkg::gmt_push_type      push
);
   import gmt_pkg::*;

   // Line stores: rows r-1 and r-2 from the current column on, rows r and r-1 behind it.
   logic [PIX_W-1:0] line_one_mem [MAX_WIDTH];
   logic [PIX_W-1:0] line_two_mem [MAX_WIDTH];

   front_state_type state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [PIX_W-1:0] pix_ff;
   logic [ROW_W-1:0] r_ff;
   logic [COL_W-1:0] c_ff;
   logic [PIX_W-1:0] one_c_ff, one_n_ff, two_c_ff, two_p_ff;
   logic [PIX_W-1:0] recent0_ff, recent1_ff;
   gmt_job_type      job_ff [3];
   logic [2:0]       pend_ff, pend_in;

   logic [WIDTH_W-1:0]  w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic                col_wrap;
   logic [ROW_W:0]      row_a;
   logic [COL_W-1:0]    cur_col;
   logic [ROW_W-1:0]    cur_row;
   logic [WIDTH_W-1:0]  col_next;
   logic [ROW_W:0]      row_next;
   logic                accept;
   gmt_job_type         job_calc [3];
   logic [2:0]          pend_calc;
   logic [PIX_W-1:0]    up, left, right, left_last;
   logic [1:0]          sel;
   logic [2:0]          pend_left;

   // Effective image size, clamped to the supported range.
   always_comb begin
      if (cfg_width < WIDTH_W'(2)) begin
         w_eff = WIDTH_W'(2);
      end else if (cfg_width > WIDTH_MAX) begin
         w_eff = WIDTH_MAX;
      end else begin
         w_eff = cfg_width;
      end
      h_eff = (cfg_height < HEIGHT_W'(2)) ? HEIGHT_W'(2) : cfg_height;
   end

   // Position of the incoming pixel, with a wrap if the size shrank.
   always_comb begin
      col_wrap = WIDTH_W'(col_ff) >= w_eff;
      row_a    = col_wrap ? ({1'b0, row_ff} + 1'b1) : {1'b0, row_ff};
      cur_col  = col_wrap ? '0 : col_ff;
      cur_row  = (row_a >= {1'b0, h_eff}) ? '0 : row_a[ROW_W-1:0];
      col_next = WIDTH_W'(cur_col) + 1'b1;
      row_next = {1'b0, cur_row} + 1'b1;
      accept   = req.valid && req.ready;
      col_in   = col_ff;
      row_in   = row_ff;
      if (accept) begin
         if (col_next >= w_eff) begin
            col_in = '0;
            row_in = (row_next >= {1'b0, h_eff}) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
            row_in = cur_row;
         end
      end
   end

   // Jobs for the pixel held in the calculation state.
   always_comb begin
      up        = (r_ff == ROW_W'(1)) ? pix_ff : two_c_ff;
      left      = (c_ff != '0) ? two_p_ff : one_n_ff;
      right     = ((WIDTH_W'(c_ff) + 1'b1) < w_eff) ? one_n_ff : two_p_ff;
      left_last = (c_ff >= COL_W'(2)) ? recent1_ff : pix_ff;

      job_calc[0].dx         = $signed({1'b0, right}) - $signed({1'b0, left});
      job_calc[0].dy         = $signed({1'b0, pix_ff}) - $signed({1'b0, up});
      job_calc[0].row        = r_ff - 1'b1;
      job_calc[0].col        = c_ff;
      job_calc[0].frame_done = 1'b0;

      job_calc[1].dx         = $signed({1'b0, pix_ff}) - $signed({1'b0, left_last});
      job_calc[1].dy         = '0;
      job_calc[1].row        = r_ff;
      job_calc[1].col        = c_ff - 1'b1;
      job_calc[1].frame_done = 1'b0;

      job_calc[2].dx         = '0;
      job_calc[2].dy         = '0;
      job_calc[2].row        = r_ff;
      job_calc[2].col        = c_ff;
      job_calc[2].frame_done = 1'b1;

      pend_calc[0] = r_ff != '0;
      pend_calc[1] = (r_ff == ROW_W'(h_eff - 1'b1)) && (c_ff != '0);
      pend_calc[2] = (r_ff == ROW_W'(h_eff - 1'b1)) &&
                     (WIDTH_W'(c_ff) == (w_eff - 1'b1));

      // The last present job closes the run.
      job_calc[2].last = pend_calc[2];
      job_calc[1].last = pend_calc[1] && !pend_calc[2];
      job_calc[0].last = pend_calc[0] && !pend_calc[1] && !pend_calc[2];
   end

   // Lowest pending job goes out first.
   always_comb begin
      if (pend_ff[0]) begin
         sel = 2'd0;
      end else if (pend_ff[1]) begin
         sel = 2'd1;
      end else begin
         sel = 2'd2;
      end
      pend_left = pend_ff & ~(3'b001 << sel);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req.valid) begin
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            state_in = (pend_calc != '0) ? F_PUSH : F_IDLE;
         end
         F_PUSH: begin
            if (!queue_full && pend_left == '0) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      req.ready  = 1'b0;
      push.valid = 1'b0;
      pend_in    = pend_ff;
      unique case (state_ff)
         F_IDLE: begin
            req.ready = 1'b1;
         end
         F_CALC: begin
            pend_in = pend_calc;
         end
         F_PUSH: begin
            push.valid = 1'b1;
            if (!queue_full) begin
               pend_in = pend_left;
            end
         end
         default: pend_in = '0;
      endcase
      push.job = job_ff[sel];
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         pend_ff  <= pend_in;
      end
   end

   // Line store reads and the captured pixel on accept.
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff   <= req.pixel;
         r_ff     <= cur_row;
         c_ff     <= cur_col;
         one_c_ff <= line_one_mem[cur_col];
         one_n_ff <= line_one_mem[cur_col + 1'b1];
         two_c_ff <= line_two_mem[cur_col];
         two_p_ff <= line_two_mem[cur_col - 1'b1];
      end
   end

   // Line store writes, recent pixels and job capture.
   always_ff @(posedge clock) begin
      if (state_ff == F_CALC) begin
         line_two_mem[c_ff] <= one_c_ff;
         line_one_mem[c_ff] <= pix_ff;
         recent1_ff         <= recent0_ff;
         recent0_ff         <= pix_ff;
         job_ff[0]          <= job_calc[0];
         job_ff[1]          <= job_calc[1];
         job_ff[2]          <= job_calc[2];
      end
   end

endmodule

`default_nettype wire

// ===== src/gmt_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on gmt_pkg for the job type and depth.
`default_nettype none

module gmt_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  gmt_pkg::gmt_push_type push,
   output logic                  full,
   input  wire                   pop,
   output logic                  empty,
   output gmt_pkg::gmt_job_type  head
);
   import gmt_pkg::*;

   gmt_job_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   // Pointer and fill bookkeeping.
   always_comb begin
      full     = count_ff == (QPTR_W + 1)'(QUEUE_DEPTH);
      empty    = count_ff == '0;
      do_push  = push.valid && !full;
      do_pop   = pop && !empty;
      wr_in    = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = do_pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
      head     = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push.job;
      end
   end

endmodule

`default_nettype wire

// ===== src/gmt_back.sv =====
// Back end: squares the differences, takes the square root one bit pair a cycle,
// applies the threshold and holds the result item. Depends on gmt_pkg and gmt_if.
`default_nettype none

module gmt_back (
   input  wire                      clock,
   input  wire                      reset,
   input  wire [gmt_pkg::MAG_W-1:0] cfg_threshold,
   input  wire                      empty,
   input  gmt_pkg::gmt_job_type     head,
   output logic                     pop,
   gmt_result_if.source             rsp
);
   import gmt_pkg::*;

   back_state_type     state_ff, state_in;
   gmt_job_type        job_ff;
   logic [SUMSQ_W-1:0] sumsq_ff;
   logic [TSQ_W-1:0]   tsq_ff;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [RAD_W-1:0]   root_ff, root_in;
   logic [RAD_W-1:0]   bit_ff;
   logic               out_valid_ff;
   logic [MAG_W-1:0]   mag_ff;
   logic [ROW_W-1:0]   orow_ff;
   logic [COL_W-1:0]   ocol_ff;
   logic               olast_ff, odone_ff;

   logic [PIX_W-1:0]   adx, ady;
   logic [SUMSQ_W-1:0] sumsq;
   logic [RAD_W-1:0]   trial;
   logic               load_out;
   logic               below;

   // Squares of the job at the head of the queue.
   always_comb begin
      adx   = head.dx[DIFF_W-1] ? PIX_W'(-head.dx) : head.dx[PIX_W-1:0];
      ady   = head.dy[DIFF_W-1] ? PIX_W'(-head.dy) : head.dy[PIX_W-1:0];
      sumsq = SUMSQ_W'(adx) * SUMSQ_W'(adx) + SUMSQ_W'(ady) * SUMSQ_W'(ady);
   end

   // One restoring square root step.
   always_comb begin
      trial = root_ff + bit_ff;
      if (rad_ff >= trial) begin
         rad_in  = rad_ff - trial;
         root_in = (root_ff >> 1) + bit_ff;
      end else begin
         rad_in  = rad_ff;
         root_in = root_ff >> 1;
      end
      below = TSQ_W'({sumsq_ff, 8'b0}) <= tsq_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty) begin
               state_in = B_ROOT;
            end
         end
         B_ROOT: begin
            if (bit_ff[0]) begin
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         B_IDLE: pop = !empty;
         B_ROOT: pop = 1'b0;
         B_OUT:  load_out = !out_valid_ff || rsp.ready;
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Square root datapath.
   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff   <= head;
         sumsq_ff <= sumsq;
         tsq_ff   <= TSQ_W'(cfg_threshold) * TSQ_W'(cfg_threshold);
         rad_ff   <= {sumsq, 8'b0};
         root_ff  <= '0;
         bit_ff   <= RAD_W'(1) << (RAD_W - 1);
      end else if (state_ff == B_ROOT) begin
         rad_ff  <= rad_in;
         root_ff <= root_in;
         bit_ff  <= bit_ff >> 2;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (load_out) begin
         mag_ff   <= below ? '0 : root_ff[MAG_W-1:0];
         orow_ff  <= job_ff.row;
         ocol_ff  <= job_ff.col;
         olast_ff <= job_ff.last;
         odone_ff <= job_ff.frame_done;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.magnitude   = mag_ff;
   assign rsp.out_row     = orow_ff;
   assign rsp.out_column  = ocol_ff;
   assign rsp.last_in_run = olast_ff;
   assign rsp.frame_done  = odone_ff;

endmodule

`default_nettype wire

// ===== src/gradient_magnitude_threshold_top.sv =====
// Top level of the gradient magnitude block: configuration registers and the
// front end, job queue and back end. Depends on gmt_pkg, gmt_if and the submodules.
`default_nettype none

// Takes 8-bit grey pixels in raster order and gives the central-difference
// gradient magnitude in Q4 for each pixel, one row behind, with reflect-101
// borders and a threshold at or below which the magnitude reads zero. The
// front end handles a pixel in order (accept with line store read, job
// calculation, push of the first job, then one push for each further job,
// stalled while the queue is full) and takes no new pixel until its jobs are
// pushed; last-row pixels make up to three results, first-row pixels none. The
// back end computes one result at a time (queue pop, 13 square-root steps,
// output load, held while the output is stalled), so the square-root loop sets
// the sustained rate. A four-entry job queue lets the front end run ahead.
// Line stores are undefined after reset and need no clearing pass.
module gradient_magnitude_threshold_top (
   input  wire                          clock,
   input  wire                          reset,
   gmt_pixel_if.sink                    req,
   gmt_result_if.source                 rsp,
   input  wire                          csr_write_enable,
   input  wire [gmt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire [gmt_pkg::CSR_W-1:0]     csr_write_data
);
   import gmt_pkg::*;

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [MAG_W-1:0]    thresh_ff;
   gmt_push_type        push;
   gmt_job_type         head;
   logic                full, empty, pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_write_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_write_data[HEIGHT_W-1:0];
            CSR_THRESHOLD:    thresh_ff <= csr_write_data[MAG_W-1:0];
            default:          thresh_ff <= thresh_ff;
         endcase
      end
   end

   gmt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .queue_full (full),
      .push       (push)
   );

   gmt_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (full),
      .pop   (pop),
      .empty (empty),
      .head  (head)
   );

   gmt_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_threshold (thresh_ff),
      .empty         (empty),
      .head          (head),
      .pop           (pop),
      .rsp           (rsp)
   );

endmodule

`default_nettype wire

// ===== src/gmt_checker.sv =====
// Port-level checks of the gradient magnitude block, bound to its top level.
// Depends on gmt_pkg and assert_macros.svh.
`include "assert_macros.svh"
`default_nettype none

module gmt_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      rsp_valid,
   input wire                      rsp_ready,
   input wire [gmt_pkg::MAG_W-1:0] rsp_magnitude,
   input wire                      rsp_last_in_run,
   input wire                      rsp_frame_done
);
   import gmt_pkg::*;

   // A stalled result item holds its magnitude.
   `GMT_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_magnitude))

   // The end of a frame always closes the run of its input.
   `GMT_ASSERT_IMP(a_done_last, clock, reset, rsp_valid && rsp_frame_done, rsp_last_in_run)

   // The square root never exceeds the largest possible gradient.
   `GMT_ASSERT_IMP(a_mag_range, clock, reset, rsp_valid, rsp_magnitude <= MAG_W'(MAG_MAX))

endmodule

bind gradient_magnitude_threshold_top gmt_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_magnitude   (rsp.magnitude),
   .rsp_last_in_run (rsp.last_in_run),
   .rsp_frame_done  (rsp.frame_done)
);

`default_nettype wire
